>>> hw/rtl/vnorm_pkg.sv
//------------------------------------------------------------------------------
// vnorm_pkg: shared constants for the vector Euclidean norm block
// Default sample width and length bound used by the top level.
//------------------------------------------------------------------------------
`default_nettype none

package vnorm_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_LENGTH_DEF  = 65536;

endpackage

`default_nettype wire

>>> hw/rtl/vector_euclidean_norm.sv
//------------------------------------------------------------------------------
// vector_euclidean_norm: streaming Euclidean norm of a fixed-point vector
// Squares and accumulates signed samples with a saturating sum, then takes
// the floor integer square root on the element marked last.
//------------------------------------------------------------------------------
// Elements are taken one per cycle when not stalled; each is squared in one
// stage and added into the saturating sum of squares in the next. When the
// last element of a vector reaches the sum, the request side stalls while a
// single shared restoring square-root unit produces one result bit per cycle
// over NORM_W iterations (24 at the default widths). The result sits in an
// output register, so the next vector is accumulated while the previous norm
// waits to be taken; a new root only stalls if that register is still full
// and rsp_stall is high when it completes.
// saturated is set if the sum would have passed
// MAX_LENGTH * 2^(2*(SAMPLE_BITS-1)) at any point in the vector; the sum then
// holds at that ceiling.
`default_nettype none

module vector_euclidean_norm
   import vnorm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
   localparam int SUM_W      = $clog2(MAX_LENGTH) + 2 * (SAMPLE_BITS - 1) + 1,
   localparam int NORM_W     = (SUM_W + 1) / 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [NORM_W-1:0]           rsp_norm,
   output logic                        rsp_saturated
);

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int RAD_W = 2 * NORM_W;
   localparam int REM_W = NORM_W + 2;
   localparam int CNT_W = $clog2(NORM_W + 1);
   localparam logic [SUM_W-1:0] SUM_CEILING =
      SUM_W'(MAX_LENGTH) << (2 * (SAMPLE_BITS - 1));

   typedef enum logic [1:0] {
      ST_ACCUM = 2'b01,
      ST_ROOT  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic               sq_valid_ff, sq_valid_in;
   logic               sq_last_ff, sq_last_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [NORM_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               sat_ff, sat_in;
   logic               out_valid_ff, out_valid_in;
   logic [NORM_W-1:0]  out_norm_ff, out_norm_in;
   logic               out_sat_ff, out_sat_in;

   logic [SAMPLE_BITS-1:0] mag;
   logic [SUM_W:0]         add_sum;
   logic                   add_over;
   logic [SUM_W-1:0]       acc_val;
   logic [REM_W-1:0]       rem_try;
   logic [REM_W-1:0]       trial;
   logic                   accept;
   logic                   out_free;

   assign req_stall     = (state_ff != ST_ACCUM) || (sq_valid_ff && sq_last_ff);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !out_valid_ff || !rsp_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_norm      = out_norm_ff;
   assign rsp_saturated = out_sat_ff;

   assign mag      = req_sample[SAMPLE_BITS-1] ? (~req_sample + 1'b1) : req_sample;
   assign add_sum  = {1'b0, sum_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_ff};
   assign add_over = add_sum > {1'b0, SUM_CEILING};
   assign acc_val  = add_over ? SUM_CEILING : add_sum[SUM_W-1:0];

   assign rem_try  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial    = {root_ff, 2'b01};

   always_comb begin
      state_in     = state_ff;
      sq_valid_in  = accept;
      sq_last_in   = req_last;
      sq_in        = SQ_W'(mag) * SQ_W'(mag);
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_norm_in  = out_norm_ff;
      out_sat_in   = out_sat_ff;

      case (state_ff)
         ST_ACCUM: begin
            if (sq_valid_ff) begin
               if (sq_last_ff) begin
                  rad_in   = {{(RAD_W - SUM_W){1'b0}}, acc_val};
                  sat_in   = ovf_ff || add_over;
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_ROOT;
               end else begin
                  sum_in = acc_val;
                  ovf_in = ovf_ff || add_over;
               end
            end
         end
         ST_ROOT: begin
            if (cnt_ff != CNT_W'(NORM_W)) begin
               rad_in = rad_ff << 2;
               cnt_in = cnt_ff + 1'b1;
               if (rem_try >= trial) begin
                  rem_in  = rem_try - trial;
                  root_in = {root_ff[NORM_W-2:0], 1'b1};
               end else begin
                  rem_in  = rem_try;
                  root_in = {root_ff[NORM_W-2:0], 1'b0};
               end
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_norm_in  = root_ff;
               out_sat_in   = sat_ff;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         sq_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sq_valid_ff  <= sq_valid_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_last_ff  <= sq_last_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      sat_ff      <= sat_in;
      out_norm_ff <= out_norm_in;
      out_sat_ff  <= out_sat_in;
   end

endmodule

`default_nettype wire
